>>> rtl/mup_pkg.sv
package mup_pkg;

  localparam int unsigned BoundaryMaxDef = 60;
  localparam int unsigned BndAddrW = 6;
  localparam int unsigned WinCntW = 7;

  localparam logic [2:0] KindContent  = 3'd0;
  localparam logic [2:0] KindNameChar = 3'd1;
  localparam logic [2:0] KindRestart  = 3'd2;
  localparam logic [2:0] KindNameDone = 3'd3;
  localparam logic [2:0] KindFound    = 3'd4;
  localparam logic [2:0] KindUnclosed = 3'd5;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChBack  = 8'h5c;
  localparam logic [7:0] ChQuote = 8'h22;

  localparam logic [3:0] KeyLen = 4'd9;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_req_t;

  typedef struct packed {
    logic                bnd_we;
    logic [BndAddrW-1:0] bnd_waddr;
    logic [7:0]          bnd_wdata;
    logic                bnd_re;
    logic [BndAddrW-1:0] bnd_raddr;
    logic                win_we;
    logic [BndAddrW-1:0] win_waddr;
    logic [7:0]          win_wdata;
    logic                win_re;
    logic [BndAddrW-1:0] win_raddr;
  } store_req_t;

  function automatic logic [7:0] keyword_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = 8'h66;
      4'd1: c = 8'h69;
      4'd2: c = 8'h6c;
      4'd3: c = 8'h65;
      4'd4: c = 8'h6e;
      4'd5: c = 8'h61;
      4'd6: c = 8'h6d;
      4'd7: c = 8'h65;
      4'd8: c = 8'h3d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/mup_store.sv
module mup_store import mup_pkg::*; #(
  parameter int unsigned BoundaryMax = BoundaryMaxDef
) (
  input  logic       clk_i,
  input  store_req_t req_i,
  output logic [7:0] bnd_rdata_o,
  output logic [7:0] win_rdata_o
);

  localparam int unsigned WinDepth = BoundaryMax + 2;

  logic [7:0] bnd_mem [BoundaryMax];
  logic [7:0] win_mem [WinDepth];
  logic [7:0] bnd_rdata_q;
  logic [7:0] win_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.bnd_we) begin
      bnd_mem[req_i.bnd_waddr] <= req_i.bnd_wdata;
    end
    if (req_i.bnd_re) begin
      bnd_rdata_q <= bnd_mem[req_i.bnd_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.win_we) begin
      win_mem[req_i.win_waddr] <= req_i.win_wdata;
    end
    if (req_i.win_re) begin
      win_rdata_q <= win_mem[req_i.win_raddr];
    end
  end

  assign bnd_rdata_o = bnd_rdata_q;
  assign win_rdata_o = win_rdata_q;

endmodule

>>> rtl/mup_outreg.sv
module mup_outreg import mup_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  out_req_t push_data_i,
  output logic     can_push_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic     valid_q;
  out_req_t data_q;

  assign can_push_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_push_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && can_push_o) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = data_q;

endmodule

>>> rtl/multipart_upload_parser.sv
// Multipart upload parser. Takes one body byte (or an end-of-stream request) per input request
// and reports filename characters, filename end, restarts, content bytes, a found boundary and
// an unclosed end as result requests, with last set on the final result of each input. A CR or
// LF at the window head with enough lookahead walks the stored boundary. One shared address
// adder and byte comparator do the walk one boundary byte at a time. One content byte can
// resolve several such heads. The work waits while a result waits on a stalled receiver.
// Input is stalled while a request is being worked on. One output register lets the next input
// proceed while a result waits to be taken.
module multipart_upload_parser import mup_pkg::*; #(
  parameter int unsigned BoundaryMax = BoundaryMaxDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam logic [WinCntW-1:0] WinDepth = WinCntW'(BoundaryMax + 2);
  localparam logic [BndAddrW-1:0] BndMax  = BndAddrW'(BoundaryMax);

  localparam logic [2:0] PhBoundary = 3'd0;
  localparam logic [2:0] PhSeek     = 3'd1;
  localparam logic [2:0] PhName     = 3'd2;
  localparam logic [2:0] PhHeader   = 3'd3;
  localparam logic [2:0] PhContent  = 3'd4;
  localparam logic [2:0] PhDone     = 3'd5;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SHrd  = 3'd1;
  localparam logic [2:0] SHchk = 3'd2;
  localparam logic [2:0] SCrd  = 3'd3;
  localparam logic [2:0] SCchk = 3'd4;
  localparam logic [2:0] SEnd  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [2:0]          phase_q, phase_d;
  logic [BndAddrW-1:0] blen_q, blen_d;
  logic [3:0]          kprog_q, kprog_d;
  logic                slf_q, slf_d;
  logic [BndAddrW-1:0] head_q, head_d;
  logic [WinCntW-1:0]  cnt_q, cnt_d;
  logic [BndAddrW-1:0] idx_q, idx_d;
  logic [7:0]          h_q, h_d;
  logic                off2_q, off2_d;
  logic                pend_valid_q, pend_valid_d;
  logic [2:0]          pend_kind_q, pend_kind_d;
  logic [7:0]          pend_byte_q, pend_byte_d;

  store_req_t          sreq;
  logic [7:0]          bnd_rdata, win_rdata;
  logic                push, can_push;
  out_req_t            push_data;

  logic [WinCntW-1:0]  add_op, add_sum, add_wrap;
  logic [BndAddrW-1:0] addr;
  logic                want;
  logic [2:0]          want_kind;
  logic [7:0]          want_byte;
  logic                emit_ok;
  logic [7:0]          b;
  logic [3:0]          kp;

  // shared address adder with wrap into the window
  assign add_sum  = {1'b0, head_q} + add_op;
  assign add_wrap = (add_sum >= WinDepth) ? add_sum - WinDepth : add_sum;
  assign addr     = add_wrap[BndAddrW-1:0];

  assign b       = in_req_i.data_byte;
  assign emit_ok = !pend_valid_q || can_push;
  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    blen_d       = blen_q;
    kprog_d      = kprog_q;
    slf_d        = slf_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    h_d          = h_q;
    off2_d       = off2_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_byte_d  = pend_byte_q;
    sreq         = '0;
    add_op       = '0;
    want         = 1'b0;
    want_kind    = KindContent;
    want_byte    = 8'h00;
    push         = 1'b0;
    push_data    = '0;
    kp           = '0;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          state_d = SEnd;
          if (phase_q == PhDone) begin
            state_d = SEnd;
          end else if (in_req_i.cmd) begin
            phase_d      = PhDone;
            cnt_d        = '0;
            pend_valid_d = 1'b1;
            pend_kind_d  = KindUnclosed;
            pend_byte_d  = 8'h00;
          end else begin
            unique case (phase_q)
              PhBoundary: begin
                if (b == ChCr || b == ChLf) begin
                  phase_d = PhSeek;
                  kprog_d = '0;
                end else if (blen_q < BndMax) begin
                  sreq.bnd_we    = 1'b1;
                  sreq.bnd_waddr = blen_q;
                  sreq.bnd_wdata = b;
                  blen_d         = blen_q + 1'b1;
                end
              end
              PhSeek: begin
                if (b == keyword_char(kprog_q)) begin
                  kp = kprog_q + 1'b1;
                end else begin
                  kp = (b == keyword_char(4'd0)) ? 4'd1 : 4'd0;
                end
                if (kp >= KeyLen) begin
                  kprog_d = '0;
                  phase_d = PhName;
                end else begin
                  kprog_d = kp;
                end
              end
              PhName: begin
                if (b == ChCr || b == ChLf) begin
                  pend_valid_d = 1'b1;
                  pend_kind_d  = KindNameDone;
                  pend_byte_d  = 8'h00;
                  phase_d      = PhHeader;
                  slf_d        = (b == ChLf);
                end else if (b == ChSlash || b == ChBack) begin
                  pend_valid_d = 1'b1;
                  pend_kind_d  = KindRestart;
                  pend_byte_d  = 8'h00;
                end else if (b != ChQuote) begin
                  pend_valid_d = 1'b1;
                  pend_kind_d  = KindNameChar;
                  pend_byte_d  = b;
                end
              end
              PhHeader: begin
                if (b == ChLf) begin
                  if (slf_q) begin
                    phase_d = PhContent;
                    cnt_d   = '0;
                  end
                  slf_d = 1'b1;
                end else if (b != ChCr) begin
                  slf_d = 1'b0;
                end
              end
              PhContent: begin
                add_op         = cnt_q;
                sreq.win_we    = 1'b1;
                sreq.win_waddr = addr;
                sreq.win_wdata = b;
                cnt_d          = cnt_q + 1'b1;
                state_d        = SHrd;
              end
              default: begin
                phase_d = PhDone;
              end
            endcase
          end
        end
      end
      SHrd: begin
        if (cnt_q == '0) begin
          state_d = SEnd;
        end else begin
          sreq.win_re    = 1'b1;
          sreq.win_raddr = head_q;
          state_d        = SHchk;
        end
      end
      SHchk: begin
        h_d    = win_rdata;
        off2_d = (win_rdata == ChCr);
        if (win_rdata != ChCr && win_rdata != ChLf) begin
          want      = 1'b1;
          want_kind = KindContent;
          want_byte = win_rdata;
          if (emit_ok) begin
            add_op  = WinCntW'(1);
            head_d  = addr;
            cnt_d   = cnt_q - 1'b1;
            state_d = SHrd;
          end
        end else begin
          if (cnt_q < {1'b0, blen_q} + ((win_rdata == ChCr) ? WinCntW'(2) : WinCntW'(1))) begin
            state_d = SEnd;
          end else begin
            idx_d   = '0;
            state_d = SCrd;
          end
        end
      end
      SCrd: begin
        if (blen_q == '0) begin
          want      = 1'b1;
          want_kind = KindFound;
          if (emit_ok) begin
            phase_d = PhDone;
            cnt_d   = '0;
            state_d = SEnd;
          end
        end else begin
          add_op         = WinCntW'(idx_q) + (off2_q ? WinCntW'(2) : WinCntW'(1));
          sreq.win_re    = 1'b1;
          sreq.win_raddr = addr;
          sreq.bnd_re    = 1'b1;
          sreq.bnd_raddr = idx_q;
          state_d        = SCchk;
        end
      end
      SCchk: begin
        if (win_rdata != bnd_rdata) begin
          want      = 1'b1;
          want_kind = KindContent;
          want_byte = h_q;
          if (emit_ok) begin
            add_op  = WinCntW'(1);
            head_d  = addr;
            cnt_d   = cnt_q - 1'b1;
            state_d = SHrd;
          end
        end else if (idx_q + 1'b1 == blen_q) begin
          want      = 1'b1;
          want_kind = KindFound;
          if (emit_ok) begin
            phase_d = PhDone;
            cnt_d   = '0;
            state_d = SEnd;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = SCrd;
        end
      end
      SEnd: begin
        if (!pend_valid_q) begin
          state_d = SIdle;
        end else if (can_push) begin
          push           = 1'b1;
          push_data.kind = pend_kind_q;
          push_data.out_byte = pend_byte_q;
          push_data.last = 1'b1;
          pend_valid_d   = 1'b0;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    // hold back each result until the next is known, so last can be set
    if (want && emit_ok) begin
      if (pend_valid_q) begin
        push               = 1'b1;
        push_data.kind     = pend_kind_q;
        push_data.out_byte = pend_byte_q;
        push_data.last     = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_kind_d  = want_kind;
      pend_byte_d  = want_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      phase_q      <= PhBoundary;
      blen_q       <= '0;
      kprog_q      <= '0;
      slf_q        <= 1'b0;
      head_q       <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      off2_q       <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      blen_q       <= blen_d;
      kprog_q      <= kprog_d;
      slf_q        <= slf_d;
      head_q       <= head_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      off2_q       <= off2_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q         <= h_d;
    pend_kind_q <= pend_kind_d;
    pend_byte_q <= pend_byte_d;
  end

  mup_store #(
    .BoundaryMax(BoundaryMax)
  ) u_store (
    .clk_i      (clk_i),
    .req_i      (sreq),
    .bnd_rdata_o(bnd_rdata),
    .win_rdata_o(win_rdata)
  );

  mup_outreg u_outreg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .can_push_o (can_push),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

endmodule
